FILE: src/lcd_drc_pkg.sv
// Package for the LCD display RAM controller: beat types, instruction codes,
// sequencer states, pointer step helper and the 5x7 font table.
// No dependencies.
package lcd_drc_pkg;

    localparam int RAM_DEPTH     = 128;
    localparam int RAM_AW        = $clog2(RAM_DEPTH);
    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_BITS    = 8 * GLYPH_COLUMNS;
    localparam int COL_W         = $clog2(GLYPH_COLUMNS);
    localparam int FONT_ROWS     = 159;

    // command field codes
    localparam logic [1:0] CMD_INSTR = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // instruction masks, in decode priority
    localparam logic [7:0] MSK_WRCURS = 8'h7D;
    localparam logic [7:0] MSK_CLCURS = 8'h7C;
    localparam logic [7:0] MODE_CHR_R = 8'h72;
    localparam logic [7:0] MODE_CHR_L = 8'h71;
    localparam logic [7:0] MODE_OR    = 8'h6C;
    localparam logic [7:0] MODE_AND   = 8'h68;
    localparam logic [7:0] MODE_WR    = 8'h64;
    localparam logic [7:0] MODE_RD    = 8'h60;
    localparam logic [7:0] MODE_RD_HI = 8'h63;
    localparam logic [7:0] MSK_WRFAM  = 8'hFC;
    localparam logic [7:0] MODE_RESET = 8'h64;
    localparam logic [7:0] FONT_FIRST = 8'h20;

    // pointer step directions
    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] returned_byte;
        logic       serial_bit;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LOAD,
        S_RD_BIT,
        S_LOAD,
        S_BITMOD,
        S_WR,
        S_CHAR,
        S_OUT
    } t_state;

    function automatic logic [6:0] f_step(input logic [6:0] ptr, input logic [1:0] dir);
        logic [6:0] r;
        begin
            r = ptr;
            if (dir == DIR_UP) begin
                r = ptr + 7'd1;
            end else if (dir == DIR_DOWN) begin
                r = ptr - 7'd1;
            end
            return r;
        end
    endfunction

    function automatic logic f_match(input logic [7:0] c, input logic [7:0] m);
        return (c & m) == m;
    endfunction

    // column 0 in the top byte
    localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [0:FONT_ROWS-1] = '{
        40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14,
        40'h2C2A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h00001C2241, 40'h41221C0000, 40'h14083E0814, 40'h08083E0808,
        40'h5030000000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E41494978,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h007F444438, 40'h3844444448,
        40'h003844447F, 40'h3854545458, 40'h00047E0501, 40'h085454543C,
        40'h007F040478, 40'h00447D4000, 40'h2040403D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04780478, 40'h007C040478, 40'h3844444438,
        40'h7C14141408, 40'h081414147C, 40'h007C080404, 40'h5854545430,
        40'h00043E4440, 40'h003C40407C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h000C50503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0402040804, 40'h7F7F7F7F7F,
        40'h0000000000, 40'h7050700000, 40'h00000F0101, 40'h4040780000,
        40'h1020400000, 40'h000C0C0000, 40'h0A0A4A2A1E, 40'h044434140C,
        40'h2010780400, 40'h18084C4838, 40'h4848784848, 40'h4828187C08,
        40'h087C082818, 40'h4048487840, 40'h5454547C00, 40'h1800584038,
        40'h0808080808, 40'h01413D0907, 40'h10087C0201, 40'h0E0243221E,
        40'h42427E4242, 40'h22120A7F02, 40'h423F02423E, 40'h0A0A7F0A0A,
        40'h084642221E, 40'h0403423E02, 40'h424242427E, 40'h024F221F02,
        40'h4A4A40201C, 40'h4222122A46, 40'h023F424A46, 40'h064840201E,
        40'h08464A321E, 40'h0A4A3E0908, 40'h0E004E201E, 40'h04453D0504,
        40'h007F081000, 40'h44241F0404, 40'h4042424240, 40'h422A122A06,
        40'h22127B1622, 40'h0040201F00, 40'h7800020478, 40'h3F44444444,
        40'h024242221E, 40'h0402040830, 40'h32027F0232, 40'h021222520E,
        40'h202A2A2A40, 40'h3824222070, 40'h4028102806, 40'h0A3E4A4A4A,
        40'h4042427E40, 40'h4A4A4A4A7E, 40'h040545251C, 40'h0F40201F00,
        40'h78007C4030, 40'h7E40201008, 40'h7E4242427E, 40'h0E0242221E,
        40'h4242402018, 40'h0408020400, 40'h0705070000
    };

    function automatic logic [GLYPH_BITS-1:0] f_glyph(input logic [7:0] code);
        logic [7:0] idx;
        begin
            idx = code - FONT_FIRST;
            if (code >= FONT_FIRST && idx < 8'(FONT_ROWS)) begin
                return GLYPH_ROM[idx];
            end
            return '0;
        end
    endfunction

endpackage

FILE: src/lcd_display_ram_controller_core.sv
// Top level of the LCD display RAM controller: sequencer, pointer, mode and
// read shift registers. Depends on lcd_drc_pkg and lcd_drc_ram.
//
// One input beat carries an instruction byte, a data byte or a serial read
// tick; each produces exactly one output beat (returned_byte, serial_bit).
// The block works on one beat at a time and holds o_in_stall high while busy.
// All RAM traffic goes through one single-port display RAM with a registered
// read. Every beat passes accept and output; between them a character write
// writes once per font column, a bit set/reset or read-mode reload reads the
// RAM then modifies or loads, a plain data write writes once, others nothing.
// A finished result sits in the output register, so the next beat may be
// accepted while it waits. RAM contents read as zero until written, tracked
// by per-entry valid flops cleared at reset, so no clearing pass is needed.
module lcd_display_ram_controller_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  lcd_drc_pkg::t_in_beat  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lcd_drc_pkg::t_out_beat o_out
);
    import lcd_drc_pkg::*;

    t_state                r_state, n_state;
    logic [6:0]            r_ptr, n_ptr;
    logic [7:0]            r_mode, n_mode;
    logic [7:0]            r_shift, n_shift;
    logic [2:0]            r_idx, n_idx;
    logic [7:0]            r_val, n_val;
    logic [GLYPH_BITS-1:0] r_glyph, n_glyph;
    logic [COL_W-1:0]      r_col, n_col;
    logic [7:0]            r_ret, n_ret;
    logic                  r_bit, n_bit;
    logic                  r_rd_ok, n_rd_ok;
    logic [RAM_DEPTH-1:0]  r_vld;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out, n_out;

    logic                  accept;
    logic                  ptr_in;
    logic [RAM_AW-1:0]     ram_addr;
    logic                  ram_we;
    logic [7:0]            ram_wdata;
    logic [7:0]            ram_rdata;
    logic [7:0]            rd_eff;
    logic                  rd_mode;
    logic [7:0]            bitmask;

    lcd_drc_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign ptr_in   = ({1'b0, r_ptr} < 8'(RAM_DEPTH));
    assign ram_addr = r_ptr[RAM_AW-1:0];
    assign rd_eff   = r_rd_ok ? ram_rdata : 8'h00;
    assign rd_mode  = r_mode inside {[MODE_RD:MODE_RD_HI]};
    assign bitmask  = 8'h01 << r_val[4:2];

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_mode      = r_mode;
        n_shift     = r_shift;
        n_idx       = r_idx;
        n_val       = r_val;
        n_glyph     = r_glyph;
        n_col       = r_col;
        n_ret       = r_ret;
        n_bit       = r_bit;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_wdata   = r_val;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val   = i_in.value;
                    n_ret   = 8'h00;
                    n_bit   = 1'b1;
                    n_state = S_OUT;
                    case (i_in.command)
                        CMD_INSTR: begin
                            if (i_in.value[7]) begin
                                // load pointer; reload shift if reading
                                n_ptr = i_in.value[6:0];
                                if (rd_mode) begin
                                    n_state = S_RD_LOAD;
                                end
                            end else if (f_match(i_in.value, MSK_WRCURS) ||
                                         f_match(i_in.value, MSK_CLCURS)) begin
                                n_state = S_OUT;
                            end else if (f_match(i_in.value, MODE_CHR_R) ||
                                         f_match(i_in.value, MODE_CHR_L) ||
                                         f_match(i_in.value, MODE_OR) ||
                                         f_match(i_in.value, MODE_AND) ||
                                         f_match(i_in.value, MODE_WR) ||
                                         f_match(i_in.value, MODE_RD)) begin
                                n_mode = i_in.value;
                                n_ret  = i_in.value;
                                if (i_in.value inside {[MODE_RD:MODE_RD_HI]}) begin
                                    n_state = S_RD_LOAD;
                                end
                            end else if (i_in.value[6] || i_in.value[5]) begin
                                n_state = S_RD_BIT;
                            end
                        end
                        CMD_DATA: begin
                            if (r_mode == MODE_CHR_R || r_mode == MODE_CHR_L) begin
                                n_glyph = f_glyph(i_in.value);
                                n_col   = '0;
                                n_state = S_CHAR;
                            end else if ((r_mode & MSK_WRFAM) == MODE_WR) begin
                                n_state = S_WR;
                            end
                        end
                        CMD_TICK: begin
                            if (rd_mode) begin
                                n_bit = r_shift[r_idx];
                                if (r_idx == 3'd0) begin
                                    n_state = S_RD_LOAD;
                                end else begin
                                    n_idx = r_idx - 3'd1;
                                end
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RD_LOAD: begin
                n_rd_ok = ptr_in && r_vld[ram_addr];
                n_state = S_LOAD;
            end
            S_RD_BIT: begin
                n_rd_ok = ptr_in && r_vld[ram_addr];
                n_state = S_BITMOD;
            end
            S_LOAD: begin
                n_shift = rd_eff;
                n_idx   = 3'd7;
                n_ptr   = f_step(r_ptr, r_mode[1:0]);
                n_state = S_OUT;
            end
            S_BITMOD: begin
                ram_we    = ptr_in;
                ram_wdata = r_val[6] ? (rd_eff | bitmask) : (rd_eff & ~bitmask);
                n_ptr     = f_step(r_ptr, r_val[1:0]);
                n_state   = S_OUT;
            end
            S_WR: begin
                ram_we    = ptr_in;
                ram_wdata = r_val;
                n_ptr     = f_step(r_ptr, r_mode[1:0]);
                n_state   = S_OUT;
            end
            S_CHAR: begin
                // last column first: it sits in the low byte
                ram_we    = ptr_in;
                ram_wdata = r_glyph[7:0];
                n_glyph   = r_glyph >> 8;
                n_ptr     = f_step(r_ptr, (r_mode == MODE_CHR_R) ? DIR_UP : DIR_DOWN);
                if (r_col == COL_W'(GLYPH_COLUMNS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out.returned_byte = r_ret;
                    n_out.serial_bit    = r_bit;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= 7'd0;
            r_mode      <= MODE_RESET;
            r_shift     <= 8'h00;
            r_idx       <= 3'd7;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_mode      <= n_mode;
            r_shift     <= n_shift;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_vld[ram_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_glyph <= n_glyph;
        r_col   <= n_col;
        r_ret   <= n_ret;
        r_bit   <= n_bit;
        r_rd_ok <= n_rd_ok;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // every accepted beat takes the sequencer out of idle in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("sequencer stayed idle after accept");

    // column counter stays within the glyph
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHAR |-> r_col < COL_W'(GLYPH_COLUMNS))
        else $error("glyph column counter out of range");

    // a new result comes only from the output state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("output loaded outside output state");

    // RAM is written only by the write states
    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_WR || r_state == S_CHAR || r_state == S_BITMOD))
        else $error("RAM write from unexpected state");

endmodule

FILE: src/lcd_drc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module lcd_drc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
